// ===== rtl/pmx_permutation_crossover_core_defines.svh =====
// assertion macros for the pmx crossover core
// used by rtl/pmx_permutation_crossover_core.sv, needs clk_i and rst_ni in scope
`ifndef PMX_PERMUTATION_CROSSOVER_CORE_DEFINES_SVH
`define PMX_PERMUTATION_CROSSOVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define PMX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pmx assertion failed");

// next-cycle implication, checked outside reset
`define PMX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pmx assertion failed");

`else

`define PMX_ASSERT_IMPL(lbl, ante, cons)
`define PMX_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/pmx_pkg.sv =====
// shared constants, types and helpers for the pmx crossover core
// no dependencies
package pmx_pkg;

  localparam int PermLen    = 8;
  localparam int SymW       = 3;
  localparam int WordW      = PermLen * SymW;
  localparam int ChainSteps = 4;

  typedef logic [SymW-1:0]              sym_t;
  typedef logic [PermLen-1:0][SymW-1:0] sym_arr_t;
  typedef logic [PermLen-1:0]           lane_mask_t;

  // everything the mapping chain stages carry along
  typedef struct packed {
    sym_arr_t   pf;
    sym_arr_t   ps;
    sym_arr_t   map;   // position in ps of pf[x]
    sym_arr_t   x;     // chain position, one per lane
    lane_mask_t seg;
    lane_mask_t need;  // lane still has a symbol to place
    logic       err;
  } chain_t;

  // symbols are SymW bits and PermLen is 2**SymW, so range is always met
  function automatic logic is_perm(sym_arr_t sym);
    lane_mask_t seen;
    seen = '0;
    for (int i = 0; i < PermLen; i++) begin
      seen[sym[i]] = 1'b1;
    end
    return &seen;
  endfunction

endpackage

// ===== rtl/pmx_if.sv =====
// valid/ready stream interfaces for the pmx crossover core
// depends on pmx_pkg
interface pmx_in_if;
  logic                       valid;
  logic                       ready;
  logic [pmx_pkg::WordW-1:0]  parent_first;
  logic [pmx_pkg::WordW-1:0]  parent_second;
  logic [pmx_pkg::SymW-1:0]   cut_start;
  logic [pmx_pkg::SymW-1:0]   cut_end;

  modport source (output valid, parent_first, parent_second, cut_start, cut_end,
                  input ready);
  modport sink   (input valid, parent_first, parent_second, cut_start, cut_end,
                  output ready);
endinterface

interface pmx_out_if;
  logic                       valid;
  logic                       ready;
  logic [pmx_pkg::WordW-1:0]  child;
  logic                       input_error;

  modport source (output valid, child, input_error, input ready);
  modport sink   (input valid, child, input_error, output ready);
endinterface

// ===== rtl/pmx_chain_stage.sv =====
// several steps of the pmx mapping chain, all lanes side by side
// depends on pmx_pkg
module pmx_chain_stage (
  input  pmx_pkg::chain_t chain_i,
  output pmx_pkg::chain_t chain_o
);

  pmx_pkg::sym_arr_t x;

  always_comb begin
    x = chain_i.x;
    for (int s = 0; s < pmx_pkg::ChainSteps; s++) begin
      for (int i = 0; i < pmx_pkg::PermLen; i++) begin
        // stay put once the chain has left the segment
        if (chain_i.seg[x[i]]) begin
          x[i] = chain_i.map[x[i]];
        end
      end
    end
    chain_o   = chain_i;
    chain_o.x = x;
  end

endmodule

// ===== rtl/pmx_permutation_crossover_core.sv =====
// top level of the pmx crossover core: pipeline registers and handshake
// depends on pmx_pkg, pmx_if, pmx_chain_stage and the defines header
//
// usage
//   in_i carries one crossover request per item: two parent permutations of
//   eight 3-bit symbols (position 0 in the low bits) and two cut points; the
//   cuts may come in either order. out_o carries one child per item, plus
//   input_error when either parent is not a permutation (child is then the
//   second parent unchanged).
//   throughput: one item per cycle while the receiver keeps out_o.ready
//   high; five register stages (input, mapping table, two stages of four
//   chain steps each, output) each with its own valid bit.
//   reset: all valid bits clear, the pipeline comes up empty and ready.
//   stall: each stage holds while the one after it is full and blocked, so a
//   stalled receiver fills the bubbles first and in_i.ready drops only when
//   every stage holds an item.
`include "pmx_permutation_crossover_core_defines.svh"

module pmx_permutation_crossover_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  pmx_in_if.sink           in_i,
  pmx_out_if.source        out_o
);

  // stage valid bits and payload
  logic                         s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic                         out_valid_q;
  pmx_pkg::sym_arr_t            s1_pf_q, s1_ps_q;
  pmx_pkg::sym_t                s1_cut_a_q, s1_cut_b_q;
  pmx_pkg::chain_t              s2_q, s2_d, s3_q, s3_d, s4_q, s4_d;
  logic [pmx_pkg::WordW-1:0]    child_q, child_d;
  logic                         err_q;

  // per-stage advance: a stage moves on when it is empty or its successor moves
  logic out_adv, s4_adv, s3_adv, s2_adv, s1_adv;

  assign out_adv = !out_valid_q || out_o.ready;
  assign s4_adv  = !s4_valid_q  || out_adv;
  assign s3_adv  = !s3_valid_q  || s4_adv;
  assign s2_adv  = !s2_valid_q  || s3_adv;
  assign s1_adv  = !s1_valid_q  || s2_adv;

  assign in_i.ready = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv)  s1_valid_q  <= in_i.valid;
      if (s2_adv)  s2_valid_q  <= s1_valid_q;
      if (s3_adv)  s3_valid_q  <= s2_valid_q;
      if (s4_adv)  s4_valid_q  <= s3_valid_q;
      if (out_adv) out_valid_q <= s4_valid_q;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s1_adv && in_i.valid) begin
      s1_pf_q    <= pmx_pkg::sym_arr_t'(in_i.parent_first);
      s1_ps_q    <= pmx_pkg::sym_arr_t'(in_i.parent_second);
      s1_cut_a_q <= in_i.cut_start;
      s1_cut_b_q <= in_i.cut_end;
    end
    if (s2_adv && s1_valid_q) s2_q <= s2_d;
    if (s3_adv && s2_valid_q) s3_q <= s3_d;
    if (s4_adv && s3_valid_q) s4_q <= s4_d;
    if (out_adv && s4_valid_q) begin
      child_q <= child_d;
      err_q   <= s4_q.err;
    end
  end

  // stage 1 -> 2: segment mask, mapping table, lanes that need placing
  pmx_pkg::sym_t     cut_lo, cut_hi;
  pmx_pkg::sym_arr_t inv_ps;
  logic              present;

  always_comb begin
    // reversed cuts are swapped; cuts cannot exceed the last position
    if (s1_cut_b_q < s1_cut_a_q) begin
      cut_lo = s1_cut_b_q;
      cut_hi = s1_cut_a_q;
    end else begin
      cut_lo = s1_cut_a_q;
      cut_hi = s1_cut_b_q;
    end

    // position of each symbol in the second parent
    inv_ps = '0;
    for (int k = 0; k < pmx_pkg::PermLen; k++) begin
      inv_ps[s1_ps_q[k]] = pmx_pkg::sym_t'(k);
    end

    s2_d     = '0;
    s2_d.pf  = s1_pf_q;
    s2_d.ps  = s1_ps_q;
    s2_d.err = !pmx_pkg::is_perm(s1_pf_q) || !pmx_pkg::is_perm(s1_ps_q);
    for (int p = 0; p < pmx_pkg::PermLen; p++) begin
      s2_d.seg[p] = (pmx_pkg::sym_t'(p) >= cut_lo) && (pmx_pkg::sym_t'(p) <= cut_hi);
      s2_d.map[p] = inv_ps[s1_pf_q[p]];
      // chain starts at its own position, which lies in the segment for every lane that needs placing
      s2_d.x[p]   = pmx_pkg::sym_t'(p);
    end
    for (int i = 0; i < pmx_pkg::PermLen; i++) begin
      present = 1'b0;
      for (int j = 0; j < pmx_pkg::PermLen; j++) begin
        if (s2_d.seg[j] && (s1_pf_q[j] == s1_ps_q[i])) present = 1'b1;
      end
      s2_d.need[i] = s2_d.seg[i] && !present;
    end
  end

  // stages 2 -> 3 and 3 -> 4: four chain steps each, eight in all
  pmx_chain_stage u_chain_a (
    .chain_i (s2_q),
    .chain_o (s3_d)
  );

  pmx_chain_stage u_chain_b (
    .chain_i (s3_q),
    .chain_o (s4_d)
  );

  // stage 4 -> output: assemble the child
  always_comb begin
    for (int p = 0; p < pmx_pkg::PermLen; p++) begin
      if (s4_q.seg[p]) begin
        child_d[p*pmx_pkg::SymW +: pmx_pkg::SymW] = s4_q.pf[p];
      end else begin
        child_d[p*pmx_pkg::SymW +: pmx_pkg::SymW] = s4_q.ps[p];
        // at most one lane lands on any position for real permutations
        for (int i = 0; i < pmx_pkg::PermLen; i++) begin
          if (s4_q.need[i] && !s4_q.seg[s4_q.x[i]] &&
              (s4_q.x[i] == pmx_pkg::sym_t'(p))) begin
            child_d[p*pmx_pkg::SymW +: pmx_pkg::SymW] = s4_q.ps[i];
          end
        end
      end
    end
    // bad parent passes the second parent through
    if (s4_q.err) child_d = pmx_pkg::WordW'(s4_q.ps);
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.child       = child_q;
  assign out_o.input_error = err_q;

  // only segment positions can be lanes that still need placing
  `PMX_ASSERT_IMPL(a_need_in_seg, s2_valid_q, (s2_q.need & ~s2_q.seg) == '0)

  // after eight steps the chain of lane 0 of a good item has left the segment, if that lane needs placing
  `PMX_ASSERT_IMPL(a_chain_exits, s4_valid_q && !s4_q.err,
                   s4_q.seg[s4_q.x[0]] == 1'b0 || !s4_q.need[0])

  // a good item always yields a permutation
  `PMX_ASSERT_IMPL(a_child_perm, out_valid_q && !err_q,
                   pmx_pkg::is_perm(pmx_pkg::sym_arr_t'(child_q)))

  // input back-pressure only when the whole pipeline is full and stalled
  `PMX_ASSERT_IMPL(a_ready_low, !in_i.ready,
                   out_valid_q && !out_o.ready && s4_valid_q && s1_valid_q)

  // a taken result that was not replaced leaves the output empty
  `PMX_ASSERT_NEXT(a_out_drain, out_valid_q && out_o.ready && !s4_valid_q,
                   !out_valid_q)

endmodule

// ===== tb/pmx_permutation_crossover_core_test.sv =====
// self-checking testbench for the pmx crossover core: valid/ready drive, random stalls
// depends on pmx_pkg, pmx_if and the core; predicts each child and compares in order
module pmx_permutation_crossover_core_test;

  localparam int CycleLimit   = 300000;
  localparam int HoldCycles   = 80;
  localparam int RandomItems  = 990;
  localparam int ChunkItems   = 66;
  localparam int SettleCycles = 8;

  // expected child per accepted item, oldest first
  class crossover_scoreboard;
    typedef struct {
      pmx_pkg::sym_arr_t child;
      logic              bad;
    } child_t;

    child_t child_q[$];
    int     errors;
    int     n_items;
    int     n_bad;
    int     n_swapped;
    int     n_single;
    int     n_checked;

    function new();
      errors    = 0;
      n_items   = 0;
      n_bad     = 0;
      n_swapped = 0;
      n_single  = 0;
      n_checked = 0;
    endfunction

    function int pending();
      return child_q.size();
    endfunction

    // pmx child of two parents, second parent passed through on a bad parent
    function automatic void crossover_child(input pmx_pkg::sym_arr_t pf,
                                            input pmx_pkg::sym_arr_t ps,
                                            input pmx_pkg::sym_t cut_a,
                                            input pmx_pkg::sym_t cut_b,
                                            output pmx_pkg::sym_arr_t child,
                                            output logic bad);
      pmx_pkg::lane_mask_t seen_f;
      pmx_pkg::lane_mask_t seen_s;
      int         lo;
      int         hi;
      int         x;
      int         nx;
      logic       present;
      logic       escaped;
      seen_f = '0;
      seen_s = '0;
      for (int i = 0; i < pmx_pkg::PermLen; i++) begin
        seen_f[pf[i]] = 1'b1;
        seen_s[ps[i]] = 1'b1;
      end
      bad   = !((&seen_f) && (&seen_s));
      child = ps;
      if (bad) begin
        return;
      end
      // 3-bit cuts never exceed the last position, so no clamping here
      lo = int'(cut_a);
      hi = int'(cut_b);
      if (hi < lo) begin
        lo = int'(cut_b);
        hi = int'(cut_a);
      end
      for (int i = lo; i <= hi; i++) begin
        child[i] = pf[i];
      end
      for (int i = lo; i <= hi; i++) begin
        present = 1'b0;
        for (int j = lo; j <= hi; j++) begin
          if (pf[j] == ps[i]) present = 1'b1;
        end
        if (!present) begin
          x       = i;
          escaped = 1'b0;
          // follow the mapping until it lands outside the segment
          for (int step = 0; step < pmx_pkg::PermLen && !escaped; step++) begin
            nx = 0;
            for (int k = 0; k < pmx_pkg::PermLen; k++) begin
              if (ps[k] == pf[x]) nx = k;
            end
            x       = nx;
            escaped = (x < lo) || (x > hi);
          end
          if (escaped) child[x] = ps[i];
        end
      end
    endfunction

    function void note_crossover(pmx_pkg::sym_arr_t pf, pmx_pkg::sym_arr_t ps,
                                 pmx_pkg::sym_t cut_a, pmx_pkg::sym_t cut_b);
      child_t exp_child;
      crossover_child(pf, ps, cut_a, cut_b, exp_child.child, exp_child.bad);
      child_q.push_back(exp_child);
      n_items++;
      if (exp_child.bad) n_bad++;
      if (cut_b < cut_a) n_swapped++;
      if (cut_a == cut_b) n_single++;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s", what);
    endtask

    task check_child(pmx_pkg::sym_arr_t child, logic input_error);
      child_t exp_child;
      if (child_q.size() == 0) begin
        report($sformatf("child %06h with no item outstanding", child));
        return;
      end
      exp_child = child_q.pop_front();
      n_checked++;
      if (child !== exp_child.child)
        report($sformatf("result %0d child %06h, expected %06h",
                         n_checked, child, exp_child.child));
      if (input_error !== exp_child.bad)
        report($sformatf("result %0d input_error %b, expected %b",
                         n_checked, input_error, exp_child.bad));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int   cycle_count;
  logic tx_idle;
  logic rx_idle;
  logic hold_rx;

  pmx_in_if  in_if ();
  pmx_out_if out_if ();

  crossover_scoreboard sb;

  pmx_permutation_crossover_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic pmx_pkg::sym_arr_t shuffled_perm();
    pmx_pkg::sym_arr_t p;
    pmx_pkg::sym_t     t;
    int                j;
    for (int i = 0; i < pmx_pkg::PermLen; i++) p[i] = pmx_pkg::sym_t'(i);
    for (int i = pmx_pkg::PermLen - 1; i > 0; i--) begin
      j    = $urandom_range(i, 0);
      t    = p[i];
      p[i] = p[j];
      p[j] = t;
    end
    return p;
  endfunction

  // rotated, optionally reversed, sequence of symbols
  function automatic pmx_pkg::sym_arr_t rotated_perm(int rot, bit rev);
    pmx_pkg::sym_arr_t p;
    for (int i = 0; i < pmx_pkg::PermLen; i++)
      p[i] = pmx_pkg::sym_t'(rev ? (pmx_pkg::PermLen - 1 - i + rot) % pmx_pkg::PermLen
                                 : (i + rot) % pmx_pkg::PermLen);
    return p;
  endfunction

  function automatic int idle_gap(logic on);
    return on ? int'($urandom_range(19, 0)) : 0;
  endfunction

  task automatic send_crossover(pmx_pkg::sym_arr_t pf, pmx_pkg::sym_arr_t ps,
                                pmx_pkg::sym_t cut_a, pmx_pkg::sym_t cut_b, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.parent_first  <= pf;
    in_if.parent_second <= ps;
    in_if.cut_start     <= cut_a;
    in_if.cut_end       <= cut_b;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    sb.note_crossover(pf, ps, cut_a, cut_b);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // receiver: random holds per result, one long hold on request
  initial begin
    int rx_wait;
    rx_wait = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_rx) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx = 1'b0;
      end else if (rx_wait > 0) begin
        out_if.ready <= 1'b0;
        @(posedge clk_i);
        rx_wait--;
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
        if (out_if.valid && out_if.ready) begin
          sb.check_child(out_if.child, out_if.input_error);
          rx_wait = idle_gap(rx_idle);
        end
      end
    end
  end

  initial begin
    pmx_pkg::sym_arr_t pf;
    pmx_pkg::sym_arr_t ps;
    pmx_pkg::sym_t     ca;
    pmx_pkg::sym_t     cb;
    int                kind;
    int                mode;
    int                pos;
    sb                  = new();
    tx_idle             = 1'b1;
    rx_idle             = 1'b1;
    hold_rx             = 1'b0;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.parent_first  = '0;
    in_if.parent_second = '0;
    in_if.cut_start     = '0;
    in_if.cut_end       = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: cut orders, segment extremes, long mapping chains, bad parents
    send_crossover(rotated_perm(0, 0), rotated_perm(0, 1), 3'd2, 3'd5, idle_gap(tx_idle));
    send_crossover(rotated_perm(0, 1), rotated_perm(0, 0), 3'd5, 3'd2, idle_gap(tx_idle));
    send_crossover(rotated_perm(0, 0), rotated_perm(0, 0), 3'd0, 3'd7, idle_gap(tx_idle));
    send_crossover(shuffled_perm(), shuffled_perm(), 3'd0, 3'd0, idle_gap(tx_idle));
    send_crossover(shuffled_perm(), shuffled_perm(), 3'd7, 3'd7, idle_gap(tx_idle));
    send_crossover(shuffled_perm(), shuffled_perm(), 3'd3, 3'd3, idle_gap(tx_idle));
    send_crossover(shuffled_perm(), shuffled_perm(), 3'd7, 3'd0, idle_gap(tx_idle));
    send_crossover(rotated_perm(1, 0), rotated_perm(0, 1), 3'd0, 3'd7, idle_gap(tx_idle));
    send_crossover(rotated_perm(0, 1), rotated_perm(3, 0), 3'd1, 3'd6, idle_gap(tx_idle));
    // rotation against identity gives chains that run through most of the segment
    send_crossover(rotated_perm(1, 0), rotated_perm(0, 0), 3'd1, 3'd6, idle_gap(tx_idle));
    send_crossover(rotated_perm(0, 0), rotated_perm(1, 0), 3'd6, 3'd1, idle_gap(tx_idle));
    send_crossover(rotated_perm(7, 0), rotated_perm(0, 0), 3'd0, 3'd6, idle_gap(tx_idle));
    send_crossover('0, rotated_perm(0, 0), 3'd2, 3'd4, idle_gap(tx_idle));
    send_crossover(rotated_perm(0, 0), '1, 3'd2, 3'd4, idle_gap(tx_idle));
    send_crossover('0, '0, 3'd0, 3'd7, idle_gap(tx_idle));
    send_crossover('1, '1, 3'd7, 3'd0, idle_gap(tx_idle));
    pf    = rotated_perm(0, 0);
    pf[5] = pf[2];
    send_crossover(pf, shuffled_perm(), 3'd1, 3'd4, idle_gap(tx_idle));
    ps    = shuffled_perm();
    ps[0] = ps[7];
    send_crossover(shuffled_perm(), ps, 3'd4, 3'd1, idle_gap(tx_idle));
    send_crossover(shuffled_perm(), shuffled_perm(), 3'd6, 3'd2, 0);
    send_crossover(shuffled_perm(), shuffled_perm(), 3'd2, 3'd6, 0);

    // back-to-back items against a long receiver hold, from an empty pipeline
    wait_drained();
    hold_rx = 1'b1;
    for (int n = 0; n < 40; n++)
      send_crossover(shuffled_perm(), shuffled_perm(), 3'($urandom_range(7, 0)),
                     3'($urandom_range(7, 0)), 0);
    wait_drained();

    // random part, idling style drawn per chunk
    for (int n = 0; n < RandomItems; n++) begin
      if (n % ChunkItems == 0) begin
        mode    = $urandom_range(3, 0);
        tx_idle = (mode == 0) || (mode == 1);
        rx_idle = (mode == 0) || (mode == 2);
        if (n == 7 * ChunkItems) wait_drained();
      end
      pf   = shuffled_perm();
      ps   = shuffled_perm();
      ca   = 3'($urandom_range(7, 0));
      cb   = 3'($urandom_range(7, 0));
      kind = $urandom_range(99, 0);
      if (kind >= 95) begin
        pf = pmx_pkg::sym_arr_t'($urandom_range(24'hFFFFFF, 0));
        ps = pmx_pkg::sym_arr_t'($urandom_range(24'hFFFFFF, 0));
      end else if (kind >= 85) begin
        // one symbol duplicated in one parent
        pos = $urandom_range(pmx_pkg::PermLen - 1, 0);
        if (kind[0]) pf[pos] = pf[(pos + 1 + $urandom_range(6, 0)) % pmx_pkg::PermLen];
        else         ps[pos] = ps[(pos + 1 + $urandom_range(6, 0)) % pmx_pkg::PermLen];
      end
      send_crossover(pf, ps, ca, cb, idle_gap(tx_idle));
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("covered %0d crossovers: %0d with a bad parent, %0d with reversed cuts,",
             sb.n_items, sb.n_bad, sb.n_swapped);
    $display("%0d single-position segments, %0d results checked, %0d mismatches",
             sb.n_single, sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
